// ===== hdl/srsw_pkg.sv =====
// Shared types and constants of the selective-repeat sender window block.
// Used by the controller, the datapath, the top level and the testbench.
package srsw_pkg;

    localparam int SEQ_SPACE_DEF = 32;

    localparam int OP_W       = 2;
    localparam int SEQ_W      = 5;
    localparam int IDX_W      = 16;
    localparam int WSIZE_W    = 6;
    localparam int WAIT_W     = 8;
    localparam int ST_W       = 2;
    localparam int TOUT_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // event codes
    localparam logic [OP_W-1:0] OP_SEND = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    // slot status codes
    localparam logic [ST_W-1:0] ST_ACKED  = 2'd0;
    localparam logic [ST_W-1:0] ST_SENT   = 2'd1;
    localparam logic [ST_W-1:0] ST_RESEND = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WSIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

    localparam logic [IDX_W-1:0]   TOTAL_RST = 16'd1;
    localparam logic [WSIZE_W-1:0] WSIZE_RST = 6'd16;
    localparam logic [WAIT_W-1:0]  LIMIT_RST = 8'd10;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [SEQ_W-1:0] ack_seq;
    } t_in_beat;

    typedef struct packed {
        logic              send_valid;
        logic [IDX_W-1:0]  send_index;
        logic [SEQ_W-1:0]  send_seq;
        logic [TOUT_W-1:0] timeouts;
        logic              all_acked;
    } t_out_beat;

    // controller to datapath strobes
    typedef struct packed {
        logic load;
        logic scan;
        logic new_rd;
        logic new_chk;
        logic mark;
        logic ack_wr;
        logic slide;
        logic fin;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scan_done;
        logic found;
        logic op_send;
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/srsw_stream_if.sv =====
// Valid/ready stream channel carrying one payload beat.
// The payload type is a parameter; beat types come from srsw_pkg.
interface srsw_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/selective_repeat_sender_window_core.sv =====
// Top level of the selective-repeat sender window block.
// Joins srsw_ctrl and srsw_dpath; channels are srsw_stream_if, types from srsw_pkg.
//
// Usage:
//   i_in carries one event per beat: opcode 0 send opportunity, 1 ack with
//   ack_seq, 2 timer tick, 3 no operation. o_out returns exactly one result
//   beat per event, in order. i_cfg_we/i_cfg_idx/i_cfg_data write
//   total_packets (0), window_size (1) and timeout_limit (2) while idle.
//   The slot memory has one read port, so the scan visits one slot per cycle,
//   and a send or tick scans at most SEQ_SPACE window slots; one event is in
//   work at a time.
//   Reset: configuration goes to 1 / 16 / 10, the window is empty at index
//   zero and per-slot valid flags make every slot read as acked with a zero
//   wait count; no clearing pass is needed.
//   Stall: a finished result sits in the output register while o_out.ready
//   is low; the next event is still accepted and worked on, and its result
//   waits until the register frees.
module selective_repeat_sender_window_core #(
    parameter int SEQ_SPACE = srsw_pkg::SEQ_SPACE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    srsw_stream_if.sink                      i_in,
    srsw_stream_if.source                    o_out,
    input  logic                             i_cfg_we,
    input  logic [srsw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [srsw_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import srsw_pkg::*;

    t_cmd      cmd;
    t_stat     stat;
    t_in_beat  in_beat;
    t_out_beat out_beat;
    logic      in_ready;
    logic      out_valid;

    assign in_beat    = i_in.data;
    assign i_in.ready = in_ready;

    srsw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_opcode   (in_beat.opcode),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    srsw_dpath #(
        .SEQ_SPACE (SEQ_SPACE)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_beat     (in_beat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_beat     (out_beat),
        .o_valid    (out_valid),
        .i_ready    (o_out.ready)
    );

    assign o_out.data  = out_beat;
    assign o_out.valid = out_valid;

endmodule

// ===== hdl/srsw_ctrl.sv =====
// Sequencer of the sender window block: walks each event through its phases.
// Depends on srsw_pkg for the command and status structs and event codes.
module srsw_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [srsw_pkg::OP_W-1:0]  i_opcode,
    output logic                       o_in_ready,
    output srsw_pkg::t_cmd             o_cmd,
    input  srsw_pkg::t_stat            i_stat
);
    import srsw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_NEW_RD,
        S_NEW_CHK,
        S_MARK,
        S_ACK_WR,
        S_SLIDE,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;
    logic   load;

    assign load       = i_in_valid && r_in_ready;
    assign o_in_ready = r_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (load) begin
                    case (i_opcode)
                        OP_SEND: n_state = S_SCAN;
                        OP_TICK: n_state = S_SCAN;
                        OP_ACK:  n_state = S_ACK_WR;
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    if (!i_stat.op_send)
                        n_state = S_FIN;
                    else if (i_stat.found)
                        n_state = S_MARK;
                    else
                        n_state = S_NEW_RD;
                end
            end
            S_NEW_RD:  n_state = S_NEW_CHK;
            S_NEW_CHK: n_state = S_MARK;
            S_MARK:    n_state = S_FIN;
            S_ACK_WR:  n_state = S_SLIDE;
            S_SLIDE: begin
                if (i_stat.scan_done)
                    n_state = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = load;
        o_cmd.scan    = (r_state == S_SCAN);
        o_cmd.new_rd  = (r_state == S_NEW_RD);
        o_cmd.new_chk = (r_state == S_NEW_CHK);
        o_cmd.mark    = (r_state == S_MARK);
        o_cmd.ack_wr  = (r_state == S_ACK_WR);
        o_cmd.slide   = (r_state == S_SLIDE);
        o_cmd.fin     = (r_state == S_FIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

`ifndef ASSERT_OFF
    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.scan, o_cmd.new_rd, o_cmd.new_chk, o_cmd.mark,
                  o_cmd.ack_wr, o_cmd.slide, o_cmd.fin}))
        else $error("more than one phase strobe active");

    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> !o_in_ready)
        else $error("input still ready right after a beat was taken");
`endif

endmodule

// ===== hdl/srsw_dpath.sv =====
// Datapath of the sender window block: slot memory, window pointers,
// scan pipeline, configuration registers and result register. Uses srsw_pkg.
module srsw_dpath #(
    parameter int SEQ_SPACE = srsw_pkg::SEQ_SPACE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  srsw_pkg::t_cmd                   i_cmd,
    output srsw_pkg::t_stat                  o_stat,
    input  srsw_pkg::t_in_beat               i_beat,
    input  logic                             i_cfg_we,
    input  logic [srsw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [srsw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output srsw_pkg::t_out_beat              o_beat,
    output logic                             o_valid,
    input  logic                             i_ready
);
    import srsw_pkg::*;

    localparam int SW = $clog2(SEQ_SPACE);
    localparam int CW = $clog2(SEQ_SPACE + 1);
    localparam int MW = ST_W + WAIT_W;
    localparam logic [SW-1:0] SLOT_MAX = SW'(SEQ_SPACE - 1);

    // configuration
    logic [IDX_W-1:0]   r_total;
    logic [WSIZE_W-1:0] r_wsize;
    logic [WAIT_W-1:0]  r_limit;

    // window
    logic [IDX_W-1:0] r_low, r_next;
    logic [SW-1:0]    r_low_slot, r_next_slot;

    // current event
    logic [OP_W-1:0]  r_op;
    logic [SEQ_W-1:0] r_ack;

    // scan pipeline
    logic [CW-1:0]    r_rem;
    logic [SW-1:0]    r_ptr;
    logic [IDX_W-1:0] r_scan_idx;
    logic             r_p1;
    logic [SW-1:0]    r_p1_slot;
    logic [IDX_W-1:0] r_p1_idx;
    logic             r_hit;
    logic [IDX_W-1:0] r_sel_idx;
    logic [SW-1:0]    r_sel_slot;
    logic [WAIT_W-1:0] r_sel_wait;
    logic [CW-1:0]    r_tcnt;

    // slot memory: status and wait count per slot
    logic [MW-1:0]        mem [SEQ_SPACE];
    logic [SEQ_SPACE-1:0] r_vld;
    logic [MW-1:0]        r_rd_data;
    logic                 r_rd_vbit;

    // result register
    t_out_beat r_out;
    logic      r_out_valid;

    logic [MW-1:0]     rd_word;
    logic [ST_W-1:0]   rd_st;
    logic [WAIT_W-1:0] rd_wait;
    logic [SW-1:0]     rd_addr;
    logic              rd_en;
    logic              more, hit_now, issue;
    logic              send_eval, tick_eval, slide_adv, new_ok;
    logic [WAIT_W:0]   wait_inc;
    logic              tick_expire;
    logic              we;
    logic [SW-1:0]     wa;
    logic [MW-1:0]     wd;
    logic [IDX_W-1:0]  diff;
    logic [CW-1:0]     span;
    logic [SW+SEQ_W-1:0] ack_wide;
    logic                ack_ok;
    logic [SW+SEQ_W-1:0] seq_wide;
    logic [CW+TOUT_W-1:0] tc_wide;
    logic              out_free;
    logic              send;
    t_out_beat         res;

    assign rd_word = r_rd_vbit ? r_rd_data : {ST_ACKED, {WAIT_W{1'b0}}};
    assign rd_st   = rd_word[MW-1 -: ST_W];
    assign rd_wait = rd_word[WAIT_W-1:0];

    assign diff = r_next - r_low;
    assign span = (diff > IDX_W'(SEQ_SPACE)) ? CW'(SEQ_SPACE) : diff[CW-1:0];

    assign ack_wide = {{SW{1'b0}}, r_ack};
    assign ack_ok   = ack_wide < (SW + SEQ_W)'(SEQ_SPACE);

    assign more = i_cmd.slide ? (r_scan_idx < r_next) : (r_rem != '0);

    assign send_eval = r_p1 && i_cmd.scan && (r_op == OP_SEND) && (rd_st == ST_RESEND);
    assign tick_eval = r_p1 && i_cmd.scan && (r_op == OP_TICK) && (rd_st == ST_SENT);
    assign slide_adv = r_p1 && i_cmd.slide && (rd_st == ST_ACKED);
    assign hit_now   = send_eval || (r_p1 && i_cmd.slide && (rd_st != ST_ACKED));
    assign issue     = (i_cmd.scan || i_cmd.slide) && more && !r_hit && !hit_now;

    assign rd_en   = issue || i_cmd.new_rd;
    assign rd_addr = i_cmd.new_rd ? r_next_slot : r_ptr;

    assign wait_inc    = {1'b0, rd_wait} + 1'b1;
    assign tick_expire = wait_inc > {1'b0, r_limit};

    assign new_ok = (r_next < r_total) && (diff < {{(IDX_W - WSIZE_W){1'b0}}, r_wsize}) &&
                    ((rd_st == ST_ACKED) || (r_next == '0));

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        o_stat           = '0;
        o_stat.scan_done = !r_p1 && (r_hit || !more);
        o_stat.found     = r_hit;
        o_stat.op_send   = (r_op == OP_SEND);
        o_stat.out_free  = out_free;
    end

    // one write per cycle: tick aging, send marking or ack clearing
    always_comb begin
        we = 1'b0;
        wa = r_p1_slot;
        wd = '0;
        if (tick_eval) begin
            we = 1'b1;
            wd = tick_expire ? {ST_RESEND, {WAIT_W{1'b0}}} : {ST_SENT, wait_inc[WAIT_W-1:0]};
        end else if (i_cmd.mark && r_hit) begin
            we = 1'b1;
            wa = r_sel_slot;
            wd = {ST_SENT, r_sel_wait};
        end else if (i_cmd.ack_wr && ack_ok) begin
            we = 1'b1;
            wa = ack_wide[SW-1:0];
            wd = {ST_ACKED, {WAIT_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we)
            mem[wa] <= wd;
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
            r_rd_vbit <= r_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (we) begin
            r_vld[wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_RST;
            r_wsize <= WSIZE_RST;
            r_limit <= LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TOTAL: r_total <= i_cfg_data;
                CFG_WSIZE: r_wsize <= i_cfg_data[WSIZE_W-1:0];
                CFG_LIMIT: r_limit <= i_cfg_data[WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    // window edges and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low       <= '0;
            r_next      <= '0;
            r_low_slot  <= '0;
            r_next_slot <= '0;
            r_p1        <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_p1 <= issue;
            if (i_cmd.load)
                r_hit <= 1'b0;
            else if (hit_now || (i_cmd.new_chk && new_ok))
                r_hit <= 1'b1;
            if (slide_adv) begin
                r_low      <= r_low + 1'b1;
                r_low_slot <= (r_low_slot == SLOT_MAX) ? '0 : r_low_slot + 1'b1;
            end
            if (i_cmd.new_chk && new_ok) begin
                r_next      <= r_next + 1'b1;
                r_next_slot <= (r_next_slot == SLOT_MAX) ? '0 : r_next_slot + 1'b1;
            end
        end
    end

    // event payload and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_beat.opcode;
            r_ack      <= i_beat.ack_seq;
            r_rem      <= span;
            r_ptr      <= r_low_slot;
            r_scan_idx <= r_low;
            r_tcnt     <= '0;
        end else begin
            if (issue) begin
                r_ptr      <= (r_ptr == SLOT_MAX) ? '0 : r_ptr + 1'b1;
                r_scan_idx <= r_scan_idx + 1'b1;
                if (i_cmd.scan)
                    r_rem <= r_rem - 1'b1;
            end
            if (tick_eval && tick_expire)
                r_tcnt <= r_tcnt + 1'b1;
        end
        if (issue) begin
            r_p1_slot <= r_ptr;
            r_p1_idx  <= r_scan_idx;
        end
        if (send_eval) begin
            r_sel_idx  <= r_p1_idx;
            r_sel_slot <= r_p1_slot;
            r_sel_wait <= rd_wait;
        end else if (i_cmd.new_chk && new_ok) begin
            r_sel_idx  <= r_next;
            r_sel_slot <= r_next_slot;
            r_sel_wait <= rd_wait;
        end
    end

    assign send     = (r_op == OP_SEND) && r_hit;
    assign seq_wide = {{SEQ_W{1'b0}}, r_sel_slot};
    assign tc_wide  = {{TOUT_W{1'b0}}, r_tcnt};

    always_comb begin
        res            = '0;
        res.send_valid = send;
        res.send_index = send ? r_sel_idx : '0;
        res.send_seq   = send ? seq_wide[SEQ_W-1:0] : '0;
        res.timeouts   = (r_op == OP_TICK) ? tc_wide[TOUT_W-1:0] : '0;
        res.all_acked  = (r_low == r_total);
    end

    // result register: load when free, hold while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin && out_free)
            r_out <= res;
    end

    assign o_beat  = r_out;
    assign o_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_low_le_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_next)
        else $error("window low edge passed next new index");

    a_tcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tcnt <= CW'(SEQ_SPACE))
        else $error("timeout count beyond slot count");

    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1 |-> $past(i_cmd.scan || i_cmd.slide))
        else $error("scan read pending outside a scan phase");
`endif

endmodule

// ===== verif/srsw_score_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the selective-repeat sender window: predicts one result per event
// from its own copy of slot states, wait counts, window edges and configuration. Needs srsw_pkg.
package srsw_score_pkg;
    import srsw_pkg::*;

    class window_scoreboard;
        logic [ST_W-1:0]    slot_state [SEQ_SPACE_DEF];
        logic [WAIT_W-1:0]  slot_age   [SEQ_SPACE_DEF];
        logic [IDX_W-1:0]   low_edge;
        logic [IDX_W-1:0]   next_fresh;
        logic [IDX_W-1:0]   total_pkts;
        logic [WSIZE_W-1:0] win_size;
        logic [WAIT_W-1:0]  limit;
        t_out_beat          pending_results [$];
        int                 mismatches;

        function new();
            foreach (slot_state[s]) begin
                slot_state[s] = ST_ACKED;
                slot_age[s]   = '0;
            end
            low_edge   = '0;
            next_fresh = '0;
            total_pkts = TOTAL_RST;
            win_size   = WSIZE_RST;
            limit      = LIMIT_RST;
            mismatches = 0;
        endfunction

        function int unsigned slot_of(logic [IDX_W-1:0] idx);
            return idx % SEQ_SPACE_DEF;
        endfunction

        // number of in-flight packets, capped at the sequence space
        function int unsigned span();
            logic [IDX_W-1:0] n;
            n = next_fresh - low_edge;
            return (n > SEQ_SPACE_DEF) ? SEQ_SPACE_DEF : n;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TOTAL: total_pkts = data;
                CFG_WSIZE: win_size   = data[WSIZE_W-1:0];
                CFG_LIMIT: limit      = data[WAIT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_event(t_in_beat ev);
            t_out_beat        r;
            logic [IDX_W-1:0] idx;
            logic [IDX_W-1:0] gap;
            logic [WAIT_W:0]  age;
            int unsigned      n;
            int unsigned      s;
            bit               hit;
            r   = '0;
            idx = '0;
            hit = 1'b0;
            n   = span();
            case (ev.opcode)
                OP_SEND: begin
                    // resends first, lowest index wins
                    for (int k = 0; k < n && !hit; k++) begin
                        idx = low_edge + k;
                        if (slot_state[slot_of(idx)] == ST_RESEND)
                            hit = 1'b1;
                    end
                    gap = next_fresh - low_edge;
                    if (!hit && next_fresh < total_pkts && gap < win_size &&
                        (slot_state[slot_of(next_fresh)] == ST_ACKED || next_fresh == '0)) begin
                        idx        = next_fresh;
                        next_fresh = next_fresh + 1'b1;
                        hit        = 1'b1;
                    end
                    if (hit) begin
                        slot_state[slot_of(idx)] = ST_SENT;
                        r.send_valid = 1'b1;
                        r.send_index = idx;
                        r.send_seq   = slot_of(idx);
                    end
                end
                OP_ACK: begin
                    slot_state[ev.ack_seq] = ST_ACKED;
                    slot_age[ev.ack_seq]   = '0;
                    while (low_edge < next_fresh && slot_state[slot_of(low_edge)] == ST_ACKED)
                        low_edge = low_edge + 1'b1;
                end
                OP_TICK: begin
                    for (int k = 0; k < n; k++) begin
                        s = slot_of(low_edge + k);
                        if (slot_state[s] == ST_SENT) begin
                            age = slot_age[s] + 1'b1;
                            if (age > limit) begin
                                slot_age[s]   = '0;
                                slot_state[s] = ST_RESEND;
                                r.timeouts    = r.timeouts + 1'b1;
                            end else begin
                                slot_age[s] = age[WAIT_W-1:0];
                            end
                        end
                    end
                end
                default: ;
            endcase
            r.all_acked = (low_edge == total_pkts);
            pending_results.push_back(r);
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat want;
            if (pending_results.size() == 0) begin
                $error("result beat with no event waiting: %p", got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare("send_valid", want.send_valid, got.send_valid);
            compare("send_index", want.send_index, got.send_index);
            compare("send_seq",   want.send_seq,   got.send_seq);
            compare("timeouts",   want.timeouts,   got.timeouts);
            compare("all_acked",  want.all_acked,  got.all_acked);
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the selective-repeat sender window testbench: drives events in bursts,
// stalls the result channel and checks every beat. Needs srsw_pkg, srsw_stream_if, srsw_score_pkg.
module tb_top;
    import srsw_pkg::*;
    import srsw_score_pkg::*;

    localparam logic [OP_W-1:0] OP_NOP = 2'd3;
    localparam int QUIET_LIMIT = 5000;
    localparam int TAIL_CYCLES = 64;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    srsw_stream_if #(.T(t_in_beat))  ev_if ();
    srsw_stream_if #(.T(t_out_beat)) res_if ();

    window_scoreboard sb = new();

    bit          ev_take  = 1'b0;
    bit          res_take = 1'b0;
    t_out_beat   res_seen;
    int unsigned stall_mode = 0;
    int unsigned mode_left  = 0;
    int unsigned quiet_cycles = 0;

    selective_repeat_sender_window_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (ev_if),
        .o_out      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        ev_if.valid  = 1'b0;
        ev_if.data   = '0;
        res_if.ready = 1'b0;
    end

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // handshakes settle by the falling edge; the next rising edge takes the beat
    always @(negedge i_clk) begin
        ev_take  = i_rst_n && ev_if.valid && ev_if.ready;
        res_take = i_rst_n && res_if.valid && res_if.ready;
        res_seen = res_if.data;
    end

    always @(posedge i_clk) begin
        if (res_take)
            sb.check_result(res_seen);
    end

    // receiver: switch between free flow, light, moderate and heavy stalling
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 96);
        end
        mode_left--;
        case (stall_mode)
            0: res_if.ready <= 1'b1;
            1: res_if.ready <= ($urandom_range(0, 7) != 0);
            2: res_if.ready <= $urandom_range(0, 1);
            default: res_if.ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (ev_take || res_take)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_in_beat ev_beat(logic [OP_W-1:0] op, logic [SEQ_W-1:0] seq);
        t_in_beat b;
        b.opcode  = op;
        b.ack_seq = seq;
        return b;
    endfunction

    // acks mostly target packets in flight so the window keeps sliding
    function automatic t_in_beat random_event(int unsigned send_pct, int unsigned tick_pct);
        int unsigned      pick;
        int unsigned      n;
        logic [SEQ_W-1:0] seq;
        logic [IDX_W-1:0] target;
        pick = $urandom_range(0, 99);
        n    = sb.span();
        seq  = $urandom_range(0, 31);
        if (pick < send_pct)
            return ev_beat(OP_SEND, seq);
        if (pick < send_pct + tick_pct)
            return ev_beat(OP_TICK, seq);
        if (pick >= 98)
            return ev_beat(OP_NOP, seq);
        if (n > 0 && $urandom_range(0, 4) != 0) begin
            target = sb.low_edge + $urandom_range(0, n - 1);
            seq    = sb.slot_of(target);
        end
        return ev_beat(OP_ACK, seq);
    endfunction

    // call at a rising edge; returns at the edge that takes the beat
    task automatic push_event(input t_in_beat ev);
        ev_if.valid <= 1'b1;
        ev_if.data  <= ev;
        do @(negedge i_clk); while (!ev_if.ready);
        @(posedge i_clk);
        sb.note_event(ev);
    endtask

    task automatic rest(input int unsigned cycles);
        ev_if.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic run_events(input int unsigned count, input int unsigned send_pct,
                              input int unsigned tick_pct);
        int unsigned left;
        int unsigned burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 16);
            if (burst > left)
                burst = left;
            repeat (burst) push_event(random_event(send_pct, tick_pct));
            left -= burst;
            if ($urandom_range(0, 2) != 0)
                rest($urandom_range(1, 8));
        end
    endtask

    // hold until every result is back; the block is idle then
    task automatic settle();
        ev_if.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(input logic [IDX_W-1:0] total, input logic [WSIZE_W-1:0] wsize,
                              input logic [WAIT_W-1:0] lim);
        settle();
        write_reg(CFG_TOTAL, total);
        write_reg(CFG_WSIZE, CFG_DATA_W'(wsize));
        write_reg(CFG_LIMIT, CFG_DATA_W'(lim));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: one packet, sent, aged, then acked
        push_event(ev_beat(OP_NOP, 5'd31));
        push_event(ev_beat(OP_SEND, 5'd0));
        push_event(ev_beat(OP_SEND, 5'd0));
        push_event(ev_beat(OP_TICK, 5'd0));
        push_event(ev_beat(OP_ACK, 5'd0));

        // zero packets in the transfer
        set_config(16'd0, 6'd0, 8'd0);
        push_event(ev_beat(OP_SEND, 5'd31));
        push_event(ev_beat(OP_NOP, 5'd0));

        // zero window: never a new packet
        set_config(16'd8, 6'd0, 8'd0);
        push_event(ev_beat(OP_SEND, 5'd0));

        // window of two, immediate timeouts, resends, out-of-order acks
        set_config(16'd8, 6'd2, 8'd0);
        push_event(ev_beat(OP_SEND, 5'd0));
        push_event(ev_beat(OP_SEND, 5'd0));
        push_event(ev_beat(OP_SEND, 5'd0));
        push_event(ev_beat(OP_TICK, 5'd0));
        push_event(ev_beat(OP_SEND, 5'd0));
        push_event(ev_beat(OP_SEND, 5'd0));
        push_event(ev_beat(OP_ACK, 5'd2));
        push_event(ev_beat(OP_ACK, 5'd1));
        push_event(ev_beat(OP_SEND, 5'd0));
        push_event(ev_beat(OP_ACK, 5'd31));
        push_event(ev_beat(OP_TICK, 5'd0));
        push_event(ev_beat(OP_ACK, 5'd3));
        push_event(ev_beat(OP_SEND, 5'd0));
        push_event(ev_beat(OP_ACK, 5'd4));

        // full window, every tick times out
        set_config(16'hFFFF, 6'd32, 8'd0);
        run_events(200, 45, 20);

        set_config(16'hFFFF, 6'd1, 8'd3);
        run_events(150, 40, 25);

        set_config(16'hFFFF, 6'd16, 8'd7);
        run_events(250, 40, 20);

        // largest limit: a sent packet times out on its 256th tick
        set_config(16'hFFFF, 6'd32, 8'd255);
        run_events(4, 100, 0);
        run_events(258, 0, 100);
        run_events(50, 40, 20);

        // run the transfer dry and ack it out
        set_config(sb.next_fresh + 16'd10, 6'd5, 8'd1);
        run_events(200, 30, 15);

        set_config(16'd1, 6'd0, 8'd2);
        run_events(60, 40, 25);

        set_config(16'hFFFF, 6'd8, 8'd4);
        run_events(100, 40, 20);

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.outstanding() != 0)
            $error("%0d results never arrived", sb.outstanding());
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== selective_repeat_sender_window_core.f =====
hdl/srsw_pkg.sv
hdl/srsw_stream_if.sv
hdl/srsw_ctrl.sv
hdl/srsw_dpath.sv
hdl/selective_repeat_sender_window_core.sv
verif/srsw_score_pkg.sv
verif/tb_top.sv
